// ===== hdl/vnl_pkg.sv =====
// vnl_pkg: types shared by the normalize pipeline
// holds the beat record handed from cell to cell; no dependencies

package vnl_pkg;

  localparam int unsigned CompW  = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned RemW   = 66;
  localparam int unsigned ProdW  = 96;
  localparam int unsigned ResW   = 130;
  localparam int unsigned Lanes  = 3;
  localparam int unsigned Steps  = 32;
  localparam logic [31:0] UnitOne   = 32'h4000_0000;
  localparam logic [31:0] LengthOne = 32'h0001_0000;

  typedef struct packed {
    logic             neg;
    logic [CompW-1:0] q;
    logic [ProdW-1:0] p;
    logic [ResW-1:0]  r;
  } lane_t;

  typedef struct packed {
    logic             vld;
    logic             zero;
    logic [SumW-1:0]  s;
    logic [RemW-1:0]  rem;
    logic [CompW-1:0] root;
    lane_t [Lanes-1:0] ln;
  } cell_t;

endpackage

// ===== hdl/vnl_cell.sv =====
// vnl_cell: one bit step of the square root and of the three quotients
// depends on vnl_pkg

module vnl_cell #(
  parameter int unsigned K = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vnl_pkg::cell_t in_i,
  output vnl_pkg::cell_t out_o
);
  import vnl_pkg::*;

  cell_t            nxt_d, cur_q;
  logic [RemW-1:0]  dl;
  logic [ResW-1:0]  t [Lanes];

  always_comb begin
    nxt_d = in_i;
    dl = (RemW'(in_i.root) << (K + 1)) + (RemW'(1) << (2 * K));
    if (in_i.rem >= dl) begin
      nxt_d.rem  = in_i.rem - dl;
      nxt_d.root = in_i.root | (CompW'(1) << K);
    end
    for (int i = 0; i < Lanes; i++) begin
      t[i] = ((ResW'(in_i.ln[i].p) << 1) + (ResW'(in_i.s) << K)) << K;
      if (in_i.ln[i].r >= t[i]) begin
        nxt_d.ln[i].r = in_i.ln[i].r - t[i];
        nxt_d.ln[i].q = in_i.ln[i].q | (CompW'(1) << K);
        nxt_d.ln[i].p = in_i.ln[i].p + (ProdW'(in_i.s) << K);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= nxt_d;
    end
  end

  assign out_o = cur_q;

endmodule

// ===== hdl/vector3_normalize_with_length_unit.sv =====
// vector3_normalize_with_length_unit: q16.16 vector to q2.30 unit vector and length
// depends on vnl_pkg and vnl_cell
// registered stages from start to done: square, sum, 32 bit cells, output
// throughput one vector per cycle; busy is always low
// reset clears every stage of the chain; output payload is not reset
// the receiver cannot stall: done_o marks a result for one cycle

module vector3_normalize_with_length_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] comp_x_i,
  input  logic [31:0] comp_y_i,
  input  logic [31:0] comp_z_i,
  output logic        done_o,
  output logic [31:0] unit_x_o,
  output logic [31:0] unit_y_o,
  output logic [31:0] unit_z_o,
  output logic [31:0] length_o,
  output logic        was_zero_o
);
  import vnl_pkg::*;

  logic [CompW-1:0] comp [Lanes];
  logic [CompW-1:0] mag  [Lanes];
  logic [Lanes-1:0] neg;
  logic [SumW-1:0]  sq_q [Lanes];
  logic [Lanes-1:0] neg_q;
  logic             v1_q;
  logic [SumW-1:0]  sum;
  cell_t            head_d, head_q;
  cell_t            chain [Steps+1];
  cell_t            tail;
  logic [CompW:0]   len;
  logic [CompW:0]   umag [Lanes];
  logic [CompW-1:0] uout [Lanes];
  logic             done_q, zero_q;
  logic [CompW-1:0] ux_q, uy_q, uz_q, len_q;

  assign busy = 1'b0;
  assign comp[0] = comp_x_i;
  assign comp[1] = comp_y_i;
  assign comp[2] = comp_z_i;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      neg[i] = comp[i][CompW-1];
      mag[i] = neg[i] ? (~comp[i] + CompW'(1)) : comp[i];
    end
  end

  // squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Lanes; i++) begin
      sq_q[i] <= SumW'(mag[i]) * SumW'(mag[i]);
    end
    neg_q <= neg;
  end

  // sum of squares and seed of the bit cells
  always_comb begin
    sum = sq_q[0] + sq_q[1] + sq_q[2];
    head_d.vld  = v1_q;
    head_d.zero = (sum == '0);
    head_d.s    = sum;
    head_d.rem  = RemW'(sum);
    head_d.root = '0;
    for (int i = 0; i < Lanes; i++) begin
      head_d.ln[i].neg = neg_q[i];
      head_d.ln[i].q   = '0;
      head_d.ln[i].p   = '0;
      head_d.ln[i].r   = ResW'(sq_q[i]) << 62;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    vnl_cell #(.K(Steps - 1 - g)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .in_i  (chain[g]),
      .out_o (chain[g+1])
    );
  end

  assign tail = chain[Steps];

  // rounding, sign and zero vector
  always_comb begin
    len = (tail.rem > RemW'(tail.root)) ? ({1'b0, tail.root} + (CompW+1)'(1))
                                        : {1'b0, tail.root};
    for (int i = 0; i < Lanes; i++) begin
      umag[i] = ({1'b0, tail.ln[i].q} + (CompW+1)'(1)) >> 1;
      uout[i] = tail.ln[i].neg ? (~umag[i][CompW-1:0] + CompW'(1))
                               : umag[i][CompW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tail.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= tail.zero;
    if (tail.zero) begin
      ux_q  <= UnitOne;
      uy_q  <= '0;
      uz_q  <= '0;
      len_q <= LengthOne;
    end else begin
      ux_q  <= uout[0];
      uy_q  <= uout[1];
      uz_q  <= uout[2];
      len_q <= len[CompW] ? '1 : len[CompW-1:0];
    end
  end

  assign done_o     = done_q;
  assign unit_x_o   = ux_q;
  assign unit_y_o   = uy_q;
  assign unit_z_o   = uz_q;
  assign length_o   = len_q;
  assign was_zero_o = zero_q;

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for vector3_normalize_with_length_unit
// drives q16.16 vectors, predicts unit vector and length, compares every beat
// depends on vnl_pkg and the rtl top level
`timescale 1ns / 100ps

module tb;

  import vnl_pkg::*;

  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic [31:0] len;
    logic        zero;
  } norm_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          known;
    norm_t       res;
  } vec_row_t;

  localparam int unsigned NumRandom = 1150;
  localparam int unsigned Latency   = 35;
  localparam int unsigned CycleCap  = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] comp_x_i = '0;
  logic [31:0] comp_y_i = '0;
  logic [31:0] comp_z_i = '0;
  logic        done_o;
  logic [31:0] unit_x_o;
  logic [31:0] unit_y_o;
  logic [31:0] unit_z_o;
  logic [31:0] length_o;
  logic        was_zero_o;

  norm_t       pending_q[$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  int unsigned zero_seen = 0;

  always #4 clk_i = ~clk_i;

  vector3_normalize_with_length_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .comp_x_i   (comp_x_i),
    .comp_y_i   (comp_y_i),
    .comp_z_i   (comp_z_i),
    .done_o     (done_o),
    .unit_x_o   (unit_x_o),
    .unit_y_o   (unit_y_o),
    .unit_z_o   (unit_z_o),
    .length_o   (length_o),
    .was_zero_o (was_zero_o)
  );

  function automatic logic [63:0] mag_of(logic [31:0] v);
    return v[31] ? 64'(33'h1_0000_0000 - {1'b0, v}) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // largest n with (2n-1)^2 * s <= m2 * 2^62
  function automatic logic [31:0] unit_mag(logic [63:0] m2, logic [63:0] s);
    logic [127:0] lim;
    logic [127:0] prod;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    logic [63:0]  d;
    lim = {64'd0, m2} << 62;
    lo = 0;
    hi = 64'(UnitOne);
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      d = 2 * mid - 1;
      prod = 128'(d * d) * 128'(s);
      if (prod <= lim) lo = mid;
      else hi = mid - 1;
    end
    return lo[31:0];
  endfunction

  function automatic norm_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    norm_t       o;
    logic [63:0] sx;
    logic [63:0] sy;
    logic [63:0] sz;
    logic [63:0] s;
    logic [63:0] rt;
    logic [63:0] ln;
    logic [31:0] m;
    sx = mag_of(x) * mag_of(x);
    sy = mag_of(y) * mag_of(y);
    sz = mag_of(z) * mag_of(z);
    s = sx + sy + sz;
    if (s == 0) begin
      o = '{UnitOne, 32'd0, 32'd0, LengthOne, 1'b1};
      return o;
    end
    rt = int_sqrt(s);
    ln = (s - rt * rt > rt) ? rt + 1 : rt;
    if (ln > 64'hFFFF_FFFF) ln = 64'hFFFF_FFFF;
    o.len = ln[31:0];
    o.zero = 1'b0;
    m = unit_mag(sx, s);
    o.ux = x[31] ? -m : m;
    m = unit_mag(sy, s);
    o.uy = y[31] ? -m : m;
    m = unit_mag(sz, s);
    o.uz = z[31] ? -m : m;
    return o;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit quiet);
    norm_t e;
    while (!quiet && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    e = normalize(x, y, z);
    start <= 1'b1;
    comp_x_i <= x;
    comp_y_i <= y;
    comp_z_i <= z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_q.push_back(e);
  endtask

  always @(posedge clk_i) begin
    norm_t e;
    norm_t a;
    if (rst_ni && done_o) begin
      a = '{unit_x_o, unit_y_o, unit_z_o, length_o, was_zero_o};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", a);
      end else begin
        e = pending_q.pop_front();
        checked++;
        if (a.zero) zero_seen++;
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ux %h uy %h uz %h len %h z %b / got %h %h %h %h %b",
                     e.ux, e.uy, e.uz, e.len, e.zero, a.ux, a.uy, a.uz, a.len, a.zero);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("vector3_normalize_with_length_unit regression: fail");
      $finish;
    end
  end

  initial begin
    vec_row_t rows[$];
    norm_t    ref_val;
    rows = '{
      '{32'd0, 32'd0, 32'd0, 1'b1, '{UnitOne, 32'd0, 32'd0, LengthOne, 1'b1}},
      '{32'h0001_0000, 32'd0, 32'd0, 1'b1, '{UnitOne, 32'd0, 32'd0, LengthOne, 1'b0}},
      '{32'd0, 32'hFFFF_0000, 32'd0, 1'b1, '{32'd0, -UnitOne, 32'd0, LengthOne, 1'b0}},
      '{32'd0, 32'd0, 32'h8000_0000, 1'b1, '{32'd0, 32'd0, -UnitOne, 32'h8000_0000, 1'b0}},
      '{32'd1, 32'd0, 32'd0, 1'b1, '{UnitOne, 32'd0, 32'd0, 32'd1, 1'b0}},
      '{32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1, '{-UnitOne, 32'd0, 32'd0, 32'd1, 1'b0}},
      '{32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1, '{UnitOne, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0}},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b0, '0},
      '{32'd3, 32'd4, 32'd0, 1'b0, '0},
      '{32'd1, 32'd1, 32'd1, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 1'b0, '0},
      '{32'd1, 32'h7FFF_FFFF, 32'd0, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 1'b0, '0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      if (rows[i].known) begin
        ref_val = normalize(rows[i].x, rows[i].y, rows[i].z);
        if (ref_val !== rows[i].res) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
        end
      end
      send(rows[i].x, rows[i].y, rows[i].z, 1'b0);
    end
    for (int unsigned n = 0; n < NumRandom; n++)
      send(rand_comp(), rand_comp(), rand_comp(), n >= 300 && n < 600);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
    $display("checked %0d vectors (%0d zero), directed table plus random mix of extremes",
             checked, zero_seen);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("vector3_normalize_with_length_unit regression: pass");
    end else begin
      $display("vector3_normalize_with_length_unit regression: fail");
    end
    $finish;
  end

endmodule
